FILE: hdl/pqsr_pkg.sv
// Shared types, codes and constants of the priority queue block.
package pqsr_pkg;

	// Default sizing, handed to the top level parameters
	localparam int CAPACITY_DEF   = 16;
	localparam int DATA_WIDTH_DEF = 16;

	// Fixed field widths of the channel words
	localparam int CMD_W   = 2;
	localparam int PRIO_W  = 8;
	localparam int TAG_W   = 16;
	localparam int STAT_W  = 2;
	localparam int COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ENQ     = 2'd0,
		CMD_LAST    = 2'd1,
		CMD_EXACT   = 2'd2,
		CMD_ATLEAST = 2'd3
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK   = 2'd0,
		STAT_MISS = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	// Sequencer states
	typedef enum logic [2:0] {
		S_IDLE,
		S_INSERT,
		S_PLACE,
		S_SEARCH,
		S_CLOSE,
		S_RESULT
	} state_t;

	// Accepted request word, as seen by the sequencer
	typedef struct packed {
		cmd_t              command;
		logic [PRIO_W-1:0] prio;
		logic [TAG_W-1:0]  data;
	} item_t;

	// Finished response word
	typedef struct packed {
		status_t            status;
		logic [TAG_W-1:0]   data;
		logic [PRIO_W-1:0]  prio;
		logic [COUNT_W-1:0] count;
	} result_t;

endpackage

FILE: hdl/pqsr_if.sv
// Request and response channel interfaces of the priority queue block.
interface pqsr_req_if;
	logic                          valid;
	logic                          ready;
	logic [pqsr_pkg::CMD_W-1:0]    command;
	logic [pqsr_pkg::PRIO_W-1:0]   priority_req;
	logic [pqsr_pkg::TAG_W-1:0]    data_in;

	modport source (output valid, output command, output priority_req, output data_in,
		input ready);
	modport sink (input valid, input command, input priority_req, input data_in,
		output ready);
endinterface

interface pqsr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [pqsr_pkg::STAT_W-1:0]   status;
	logic [pqsr_pkg::TAG_W-1:0]    data_out;
	logic [pqsr_pkg::PRIO_W-1:0]   priority_out;
	logic [pqsr_pkg::COUNT_W-1:0]  count;

	modport source (output valid, output status, output data_out, output priority_out,
		output count, input ready);
	modport sink (input valid, input status, input data_out, input priority_out,
		input count, output ready);
endinterface

FILE: hdl/priority_queue_select_remove.sv
// Top level of the sorted-array priority queue with selective removal.
//
// Usage: one request word on req (command, priority_req, data_in) gives
// exactly one response word on rsp (status, data_out, priority_out, count).
// Commands: enqueue, remove last, remove oldest of an exact priority, and
// remove the hindmost entry of at least a priority. Entries stay sorted by
// descending priority; a new entry goes in front of equal priorities.
// Operation: the sequencer moves one entry per cycle through the store's single
// read and single write port. Enqueue moves every entry at or below the new
// priority up one place; a removal scans back to the match and then shifts
// later entries down; a removal with no match scans every entry. An enqueue
// to a full store and any request on an empty store answer without a scan.
// req.ready is high only while the sequencer is idle; the next word is taken
// no earlier than the edge at which the previous response can be taken, and
// the response register lets it be accepted while that response still waits.
// If rsp stalls, a finished response holds the sequencer until the register frees.
// Reset (arst_n low) empties the store at once; stored entries are not cleared.
module priority_queue_select_remove #(
	parameter int CAPACITY   = pqsr_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pqsr_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pqsr_req_if.sink    req,
	pqsr_rsp_if.source  rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int MW = pqsr_pkg::PRIO_W + DATA_WIDTH;

	logic              idle, start, done, res_free;
	pqsr_pkg::item_t   item;
	pqsr_pkg::result_t result, rsp_q;
	logic              rsp_valid_q;
	logic              mem_rd_en, mem_wr_en;
	logic [AW-1:0]     mem_rd_addr, mem_wr_addr;
	logic [MW-1:0]     mem_rd_data, mem_wr_data;

	// Request handshake
	assign req.ready    = idle;
	assign start        = req.valid & idle;
	assign item.command = pqsr_pkg::cmd_t'(req.command);
	assign item.prio    = req.priority_req;
	assign item.data    = req.data_in;

	pqsr_ctrl #(
		.CAPACITY   (CAPACITY),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.item        (item),
		.res_free    (res_free),
		.idle        (idle),
		.done        (done),
		.result      (result),
		.mem_rd_en   (mem_rd_en),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

	pqsr_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (MW)
	) u_ram (
		.clk     (clk),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// Response register
	assign res_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_free) begin
			rsp_valid_q <= done;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_q <= result;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.data_out     = rsp_q.data;
	assign rsp.priority_out = rsp_q.prio;
	assign rsp.count        = rsp_q.count;

endmodule

FILE: hdl/pqsr_ram.sv
// Entry store: one write port, one read port with registered read data.
module pqsr_ram #(
	parameter int DEPTH = pqsr_pkg::CAPACITY_DEF,
	parameter int WIDTH = pqsr_pkg::PRIO_W + pqsr_pkg::DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port, data valid the cycle after the address
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hdl/pqsr_ctrl.sv
// Sequencer: walks the sorted store one entry a cycle to insert, find and close gaps.
module pqsr_ctrl #(
	parameter int CAPACITY   = pqsr_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = pqsr_pkg::DATA_WIDTH_DEF
) (
	input  logic                                        clk,
	input  logic                                        arst_n,
	input  logic                                        start,
	input  pqsr_pkg::item_t                             item,
	input  logic                                        res_free,
	output logic                                        idle,
	output logic                                        done,
	output pqsr_pkg::result_t                           result,
	output logic                                        mem_rd_en,
	output logic [$clog2(CAPACITY)-1:0]                 mem_rd_addr,
	input  logic [pqsr_pkg::PRIO_W+DATA_WIDTH-1:0]      mem_rd_data,
	output logic                                        mem_wr_en,
	output logic [$clog2(CAPACITY)-1:0]                 mem_wr_addr,
	output logic [pqsr_pkg::PRIO_W+DATA_WIDTH-1:0]      mem_wr_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = pqsr_pkg::PRIO_W;

	pqsr_pkg::state_t   state_q, state_d;
	logic [CW-1:0]      fill_q, fill_d;
	pqsr_pkg::cmd_t     cmd_q, cmd_d;
	logic [PW-1:0]      prio_q, prio_d;
	logic [DATA_WIDTH-1:0] data_q, data_d;
	logic [AW-1:0]      radr_q, radr_d;
	pqsr_pkg::status_t  stat_q, stat_d;
	logic [DATA_WIDTH-1:0] rdata_q, rdata_d;
	logic [PW-1:0]      rprio_q, rprio_d;

	logic [PW-1:0]         e_prio;
	logic [DATA_WIDTH-1:0] e_data;
	logic                  full, empty, e_gt, e_match, radr_zero, at_last;
	logic [AW-1:0]         last_addr;
	logic [DATA_WIDTH-1:0] new_data;

	// Shared compare unit on the entry just read
	assign e_prio    = mem_rd_data[PW+DATA_WIDTH-1:DATA_WIDTH];
	assign e_data    = mem_rd_data[DATA_WIDTH-1:0];
	assign e_gt      = e_prio > prio_q;
	always_comb begin
		case (cmd_q)
			pqsr_pkg::CMD_LAST:    e_match = 1'b1;
			pqsr_pkg::CMD_EXACT:   e_match = (e_prio == prio_q);
			pqsr_pkg::CMD_ATLEAST: e_match = (e_prio >= prio_q);
			default:               e_match = 1'b0;
		endcase
	end

	assign full      = (fill_q == CW'(CAPACITY));
	assign empty     = (fill_q == '0);
	assign last_addr = AW'(fill_q - CW'(1));
	assign radr_zero = (radr_q == '0);
	assign at_last   = (radr_q == last_addr);
	assign new_data  = DATA_WIDTH'(item.data);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			pqsr_pkg::S_IDLE: begin
				if (start) begin
					if (item.command == pqsr_pkg::CMD_ENQ) begin
						state_d = (full || empty) ? pqsr_pkg::S_RESULT : pqsr_pkg::S_INSERT;
					end else begin
						state_d = empty ? pqsr_pkg::S_RESULT : pqsr_pkg::S_SEARCH;
					end
				end
			end
			pqsr_pkg::S_INSERT: begin
				if (e_gt) begin
					state_d = pqsr_pkg::S_RESULT;
				end else if (radr_zero) begin
					state_d = pqsr_pkg::S_PLACE;
				end
			end
			pqsr_pkg::S_PLACE: state_d = pqsr_pkg::S_RESULT;
			pqsr_pkg::S_SEARCH: begin
				if (e_match) begin
					state_d = at_last ? pqsr_pkg::S_RESULT : pqsr_pkg::S_CLOSE;
				end else if (radr_zero) begin
					state_d = pqsr_pkg::S_RESULT;
				end
			end
			pqsr_pkg::S_CLOSE: begin
				if (at_last) begin
					state_d = pqsr_pkg::S_RESULT;
				end
			end
			pqsr_pkg::S_RESULT: begin
				if (res_free) begin
					state_d = pqsr_pkg::S_IDLE;
				end
			end
			default: state_d = pqsr_pkg::S_IDLE;
		endcase
	end

	// Datapath and store port control
	always_comb begin
		fill_d      = fill_q;
		cmd_d       = cmd_q;
		prio_d      = prio_q;
		data_d      = data_q;
		radr_d      = radr_q;
		stat_d      = stat_q;
		rdata_d     = rdata_q;
		rprio_d     = rprio_q;
		mem_rd_en   = 1'b0;
		mem_rd_addr = radr_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = radr_q;
		mem_wr_data = mem_rd_data;
		done        = 1'b0;
		case (state_q)
			pqsr_pkg::S_IDLE: begin
				if (start) begin
					cmd_d   = item.command;
					prio_d  = item.prio;
					data_d  = new_data;
					stat_d  = pqsr_pkg::STAT_OK;
					rdata_d = '0;
					rprio_d = '0;
					radr_d  = last_addr;
					if (item.command == pqsr_pkg::CMD_ENQ) begin
						if (full) begin
							stat_d = pqsr_pkg::STAT_FULL;
						end else if (empty) begin
							mem_wr_en   = 1'b1;
							mem_wr_addr = '0;
							mem_wr_data = {item.prio, new_data};
							fill_d      = fill_q + CW'(1);
						end else begin
							mem_rd_en   = 1'b1;
							mem_rd_addr = last_addr;
						end
					end else if (empty) begin
						stat_d = pqsr_pkg::STAT_MISS;
					end else begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = last_addr;
					end
				end
			end
			pqsr_pkg::S_INSERT: begin
				// entry moves up one place unless it outranks the new word
				mem_wr_en   = 1'b1;
				mem_wr_addr = radr_q + AW'(1);
				if (e_gt) begin
					mem_wr_data = {prio_q, data_q};
					fill_d      = fill_q + CW'(1);
				end else if (!radr_zero) begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = radr_q - AW'(1);
					radr_d      = radr_q - AW'(1);
				end
			end
			pqsr_pkg::S_PLACE: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = '0;
				mem_wr_data = {prio_q, data_q};
				fill_d      = fill_q + CW'(1);
			end
			pqsr_pkg::S_SEARCH: begin
				// scan from the back for the hindmost match
				if (e_match) begin
					rdata_d = e_data;
					rprio_d = e_prio;
					if (at_last) begin
						fill_d = fill_q - CW'(1);
					end else begin
						mem_rd_en   = 1'b1;
						mem_rd_addr = radr_q + AW'(1);
						radr_d      = radr_q + AW'(1);
					end
				end else if (radr_zero) begin
					stat_d = pqsr_pkg::STAT_MISS;
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = radr_q - AW'(1);
					radr_d      = radr_q - AW'(1);
				end
			end
			pqsr_pkg::S_CLOSE: begin
				// later entries move down one place
				mem_wr_en   = 1'b1;
				mem_wr_addr = radr_q - AW'(1);
				if (at_last) begin
					fill_d = fill_q - CW'(1);
				end else begin
					mem_rd_en   = 1'b1;
					mem_rd_addr = radr_q + AW'(1);
					radr_d      = radr_q + AW'(1);
				end
			end
			pqsr_pkg::S_RESULT: done = res_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pqsr_pkg::S_IDLE;
			fill_q  <= '0;
		end else begin
			state_q <= state_d;
			fill_q  <= fill_d;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		cmd_q   <= cmd_d;
		prio_q  <= prio_d;
		data_q  <= data_d;
		radr_q  <= radr_d;
		stat_q  <= stat_d;
		rdata_q <= rdata_d;
		rprio_q <= rprio_d;
	end

	assign idle          = (state_q == pqsr_pkg::S_IDLE);
	assign result.status = stat_q;
	assign result.data   = pqsr_pkg::TAG_W'(rdata_q);
	assign result.prio   = rprio_q;
	assign result.count  = pqsr_pkg::COUNT_W'(fill_q);

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(CAPACITY))
		else $error("fill count above capacity");

	a_wr_state: assert property (@(posedge clk) disable iff (!arst_n)
		mem_wr_en |-> (state_q == pqsr_pkg::S_IDLE && start) || state_q == pqsr_pkg::S_INSERT
			|| state_q == pqsr_pkg::S_PLACE || state_q == pqsr_pkg::S_CLOSE)
		else $error("store written outside an update step");

	a_full_stat: assert property (@(posedge clk) disable iff (!arst_n)
		done && stat_q == pqsr_pkg::STAT_FULL |-> full)
		else $error("full reported with room left");

	a_remove_room: assert property (@(posedge clk) disable iff (!arst_n)
		done && stat_q == pqsr_pkg::STAT_OK && cmd_q != pqsr_pkg::CMD_ENQ |-> !full)
		else $error("removal left the store full");

	a_fill_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pqsr_pkg::S_RESULT |=> $stable(fill_q))
		else $error("fill count moved while result waits");

endmodule
